@@ hdl/workstation_reuse_allocator_defines.svh @@
// assertion helpers shared by the checker
`ifndef WORKSTATION_REUSE_ALLOCATOR_DEFINES_SVH
`define WORKSTATION_REUSE_ALLOCATOR_DEFINES_SVH

// clocked assertion, quiet while reset is low
`define WRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also checks across reset
`define WRA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/wra_pkg.sv @@
package wra_pkg;
  localparam int MAX_SESSIONS = 1024;
  localparam int AW = $clog2(MAX_SESSIONS);
  localparam int CW = $clog2(MAX_SESSIONS + 1);
  localparam int TW = 32;
  localparam int EW = TW + 1;
  localparam int CMP_W = 2 * TW + 2;
  localparam int OUT_W = 11;
endpackage

@@ hdl/wra_cmp.sv @@
module wra_cmp (
  input  logic [wra_pkg::CMP_W-1:0] a,
  input  logic [wra_pkg::CMP_W-1:0] b,
  output logic                      gt
);
  import wra_pkg::*;

  // single shared magnitude compare, used by the load, stale, reuse and free-list compare steps
  assign gt = (a > b);
endmodule

@@ hdl/workstation_reuse_allocator.sv @@
// channel | direction | beat carries
// in      | input     | start_time, duration, last_item
// out     | output    | unlocks_avoided, stations_opened, overflow
// cfg     | input     | lock_timeout, write only
// Loading a session is an insertion into a sorted store: in_stall stays high after
// its beat while the insertion runs, each shift step a memory read and a compare.
// The last beat then runs the assignment: per session a load, the dropping of stale
// free times and the shifting of free-time entries, all through one comparator,
// then S_OUT moves the result into the output register once it is free.
// Synchronous active-low reset clears counts and control; memories are not cleared.
// in_stall is high whenever the sequencer is busy, including while a finished result
// waits for the output register; a stalled result holds its value.
module workstation_reuse_allocator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          in_start_time,
  input  logic [31:0]          in_duration,
  input  logic                 in_last_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [10:0]          out_unlocks_avoided,
  output logic [10:0]          out_stations_opened,
  output logic                 out_overflow,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_wdata
);
  import wra_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LWAIT, S_LCMP, S_LPUT, S_ARD, S_AWAIT, S_ALOAD, S_HEAD,
    S_HWAIT, S_HSTALE, S_HREUSE, S_FSTART, S_FWAIT, S_FCMP, S_FPUT, S_OUT
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt, stn_r, stn_nxt, j_r, j_nxt;
  logic [CW-1:0]   k_r, k_nxt, head_r, head_nxt, tail_r, tail_nxt;
  logic            ovf_r, ovf_nxt, last_r, last_nxt;
  logic [TW-1:0]   key_s_r, key_s_nxt, cur_s_r, cur_s_nxt, tmo_r;
  logic [EW-1:0]   key_e_r, key_e_nxt, cur_e_r, cur_e_nxt;
  logic [AW-1:0]   sraddr_r, sraddr_nxt, fraddr_r, fraddr_nxt;
  logic             out_valid_r, out_valid_nxt, out_ovf_r, out_ovf_nxt;
  logic [OUT_W-1:0] out_ua_r, out_ua_nxt, out_so_r, out_so_nxt;

  // session store {start, end} and free-time store
  logic [TW+EW-1:0] sess_mem [MAX_SESSIONS];
  logic [EW-1:0]    free_mem [MAX_SESSIONS];
  logic [TW+EW-1:0] sess_q, sess_wd;
  logic [EW-1:0]    free_q, free_wd;
  logic             sess_we, free_we;
  logic [AW-1:0]    sess_wa, free_wa;

  logic [CMP_W-1:0] cmp_a, cmp_b;
  logic             cmp_gt;

  wra_cmp u_cmp (.a(cmp_a), .b(cmp_b), .gt(cmp_gt));

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (sess_we) sess_mem[sess_wa] <= sess_wd;
    sess_q <= sess_mem[sraddr_r];
  end

  always_ff @(posedge clk) begin
    if (free_we) free_mem[free_wa] <= free_wd;
    free_q <= free_mem[fraddr_r];
  end

  // timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r <= '0;
    end else if (cfg_we) begin
      tmo_r <= cfg_wdata;
    end
  end

  // comparator operand select
  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    case (state_r)
      S_LCMP: begin
        cmp_a = CMP_W'(sess_q);
        cmp_b = CMP_W'({key_s_r, key_e_r});
      end
      S_HSTALE: begin
        cmp_a = CMP_W'(cur_s_r);
        cmp_b = CMP_W'({1'b0, free_q}) + CMP_W'(tmo_r);
      end
      S_HREUSE: begin
        cmp_a = CMP_W'(free_q);
        cmp_b = CMP_W'(cur_s_r);
      end
      S_FCMP: begin
        cmp_a = CMP_W'(free_q);
        cmp_b = CMP_W'(cur_e_r);
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    stn_nxt    = stn_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    ovf_nxt    = ovf_r;
    last_nxt   = last_r;
    key_s_nxt  = key_s_r;
    key_e_nxt  = key_e_r;
    cur_s_nxt  = cur_s_r;
    cur_e_nxt  = cur_e_r;
    sraddr_nxt = sraddr_r;
    fraddr_nxt = fraddr_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_ua_nxt    = out_ua_r;
    out_so_nxt    = out_so_r;
    out_ovf_nxt   = out_ovf_r;
    sess_we    = 1'b0;
    sess_wa    = j_r[AW-1:0];
    sess_wd    = sess_q;
    free_we    = 1'b0;
    free_wa    = j_r[AW-1:0];
    free_wd    = free_q;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_s_nxt = in_start_time;
          key_e_nxt = {1'b0, in_start_time} + {1'b0, in_duration};
          last_nxt  = in_last_item;
          if (cnt_r < CW'(MAX_SESSIONS)) begin
            j_nxt = cnt_r;
            if (cnt_r == '0) begin
              state_nxt = S_LPUT;
            end else begin
              sraddr_nxt = AW'(cnt_r - 1'b1);
              state_nxt  = S_LWAIT;
            end
          end else begin
            ovf_nxt = 1'b1;
            if (in_last_item) begin
              k_nxt     = '0;
              head_nxt  = '0;
              tail_nxt  = '0;
              state_nxt = S_ARD;
            end
          end
        end
      end
      S_LWAIT: state_nxt = S_LCMP;
      S_LCMP: begin
        if (cmp_gt) begin
          sess_we = 1'b1;
          sess_wd = sess_q;
          j_nxt   = j_r - 1'b1;
          if (j_r == CW'(1)) begin
            state_nxt = S_LPUT;
          end else begin
            sraddr_nxt = AW'(j_r - CW'(2));
            state_nxt  = S_LWAIT;
          end
        end else begin
          state_nxt = S_LPUT;
        end
      end
      S_LPUT: begin
        sess_we = 1'b1;
        sess_wd = {key_s_r, key_e_r};
        cnt_nxt = cnt_r + 1'b1;
        if (last_r) begin
          k_nxt     = '0;
          head_nxt  = '0;
          tail_nxt  = '0;
          state_nxt = S_ARD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ARD: begin
        sraddr_nxt = k_r[AW-1:0];
        state_nxt  = S_AWAIT;
      end
      S_AWAIT: state_nxt = S_ALOAD;
      S_ALOAD: begin
        cur_s_nxt = sess_q[TW+EW-1:EW];
        cur_e_nxt = sess_q[EW-1:0];
        state_nxt = S_HEAD;
      end
      // drop stale free times from the front, then test the head
      S_HEAD: begin
        if (head_r < tail_r) begin
          fraddr_nxt = head_r[AW-1:0];
          state_nxt  = S_HWAIT;
        end else begin
          stn_nxt   = stn_r + 1'b1;
          state_nxt = S_FSTART;
        end
      end
      S_HWAIT: state_nxt = S_HSTALE;
      S_HSTALE: begin
        if (cmp_gt) begin
          head_nxt  = head_r + 1'b1;
          state_nxt = S_HEAD;
        end else begin
          state_nxt = S_HREUSE;
        end
      end
      S_HREUSE: begin
        if (cmp_gt) stn_nxt = stn_r + 1'b1;
        else head_nxt = head_r + 1'b1;
        state_nxt = S_FSTART;
      end
      // sorted insert of the session end into the free list
      S_FSTART: begin
        j_nxt = tail_r;
        if (tail_r == head_r) begin
          state_nxt = S_FPUT;
        end else begin
          fraddr_nxt = AW'(tail_r - 1'b1);
          state_nxt  = S_FWAIT;
        end
      end
      S_FWAIT: state_nxt = S_FCMP;
      S_FCMP: begin
        if (cmp_gt) begin
          free_we = 1'b1;
          free_wd = free_q;
          j_nxt   = j_r - 1'b1;
          if (j_r - 1'b1 == head_r) begin
            state_nxt = S_FPUT;
          end else begin
            fraddr_nxt = AW'(j_r - CW'(2));
            state_nxt  = S_FWAIT;
          end
        end else begin
          state_nxt = S_FPUT;
        end
      end
      S_FPUT: begin
        free_we  = 1'b1;
        free_wd  = cur_e_r;
        tail_nxt = tail_r + 1'b1;
        k_nxt    = k_r + 1'b1;
        if (k_r + 1'b1 == cnt_r) state_nxt = S_OUT;
        else state_nxt = S_ARD;
      end
      // hand the tally to the output register once it is free
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_ua_nxt    = OUT_W'(cnt_r - stn_r);
          out_so_nxt    = OUT_W'(stn_r);
          out_ovf_nxt   = ovf_r;
          cnt_nxt       = '0;
          stn_nxt       = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      stn_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_ua_r    <= '0;
      out_so_r    <= '0;
      out_ovf_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      stn_r       <= stn_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      out_ua_r    <= out_ua_nxt;
      out_so_r    <= out_so_nxt;
      out_ovf_r   <= out_ovf_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    j_r      <= j_nxt;
    k_r      <= k_nxt;
    head_r   <= head_nxt;
    tail_r   <= tail_nxt;
    last_r   <= last_nxt;
    key_s_r  <= key_s_nxt;
    key_e_r  <= key_e_nxt;
    cur_s_r  <= cur_s_nxt;
    cur_e_r  <= cur_e_nxt;
    sraddr_r <= sraddr_nxt;
    fraddr_r <= fraddr_nxt;
  end

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_unlocks_avoided = out_ua_r;
  assign out_stations_opened = out_so_r;
  assign out_overflow        = out_ovf_r;
endmodule

@@ hdl/wra_checker.sv @@
`include "workstation_reuse_allocator_defines.svh"

module wra_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [10:0] out_unlocks_avoided,
  input logic [10:0] out_stations_opened,
  input logic        out_overflow
);
  import wra_pkg::*;

  logic [22:0] out_beat;
  logic [11:0] out_sum;

  assign out_beat = {out_unlocks_avoided, out_stations_opened, out_overflow};
  assign out_sum  = {1'b0, out_unlocks_avoided} + {1'b0, out_stations_opened};

  // a waiting result holds its value
  `WRA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_beat), "result changed while stalled")

  // every data set opens at least one station
  `WRA_ASSERT(a_one_station, out_valid |-> out_stations_opened != 11'd0, "result without a station")

  // stations plus avoided unlocks never exceed the store
  `WRA_ASSERT(a_count_sum, out_valid |-> out_sum <= 12'(MAX_SESSIONS), "counts exceed capacity")

  // reset leaves no result behind
  `WRA_ASSERT_RST(a_reset_clear, !rst_n |=> !out_valid && !in_stall, "state not cleared by reset")
endmodule

bind workstation_reuse_allocator wra_checker u_wra_checker (.*);
